// ----- src/pcrt_pkg.sv -----
package pcrt_pkg;

   localparam int unsigned DistW  = 20;
   localparam int unsigned SpeedW = 18;
   localparam int unsigned TimeW  = 32;
   localparam int unsigned IdW    = 48;
   localparam int unsigned CfgW   = 20;
   localparam int unsigned CfgIdxW = 3;

   localparam logic [CfgIdxW-1:0] RegAlpha    = 3'd0;
   localparam logic [CfgIdxW-1:0] RegInterval = 3'd1;
   localparam logic [CfgIdxW-1:0] RegApprOn   = 3'd2;
   localparam logic [CfgIdxW-1:0] RegApprOff  = 3'd3;
   localparam logic [CfgIdxW-1:0] RegCollDist = 3'd4;
   localparam logic [CfgIdxW-1:0] RegAlertDist = 3'd5;
   localparam logic [CfgIdxW-1:0] RegTtc      = 3'd6;

   localparam logic [1:0] RiskSafe    = 2'd0;
   localparam logic [1:0] RiskAlert   = 2'd1;
   localparam logic [1:0] RiskWarning = 2'd2;
   localparam logic [1:0] RiskDanger  = 2'd3;

   localparam int unsigned ProdW = 38;
   localparam int unsigned QuotW = 38;
   localparam logic signed [SpeedW-1:0] SpeedMax = 18'sd131071;
   localparam logic signed [SpeedW-1:0] SpeedMin = -18'sd131072;

   typedef struct packed {
      logic [8:0]  alpha;
      logic [15:0] interval;
      logic signed [SpeedW-1:0] appr_on;
      logic signed [SpeedW-1:0] appr_off;
      logic [DistW-1:0] coll_dist;
      logic [DistW-1:0] alert_dist;
      logic [15:0] ttc;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;     // latch the input item
      logic load;        // read slot state and prepare
      logic ema;         // compute smoothed distance
      logic div_start;   // start the speed division
      logic div_step;    // one quotient bit
      logic commit;      // write back slot and update scan
      logic eval;        // compute the classification products
      logic emit;        // load the result register
   } cmd_type;

   typedef struct packed {
      logic track;       // the item updates a slot
      logic seed;        // the slot is seeded, no speed update
      logic skip;        // the interval has not elapsed
      logic last;        // the item closes a scan
      logic div_done;
   } sts_type;

endpackage

// ----- src/proximity_collision_risk_tracker_core.sv -----
// Proximity collision risk tracker. Each item is one distance report for a
// cyclist slot; the item with last_in_scan set closes a scan and yields one
// result naming the nearest tracked slot and its risk level. Items are taken
// one at a time: a report that updates a slot passes through a 38-step serial
// divider for the closing speed; a seeding or skipped report bypasses the
// divider, a report that is not tracked also skips the write-back, and a scan end
// adds the evaluate and emit states plus any wait on the result side.
module proximity_collision_risk_tracker_core
   import pcrt_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = 8
)
(
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [CfgIdxW-1:0] csr_index,
   input  logic [CfgW-1:0] csr_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic req_gps_valid,
   input  logic req_present,
   input  logic [2:0] req_slot,
   input  logic [IdW-1:0] req_sender_id,
   input  logic [DistW-1:0] req_raw_distance_cm,
   input  logic [TimeW-1:0] req_now_ms,
   input  logic req_last_in_scan,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_risk_level,
   output logic rsp_closest_found,
   output logic [2:0] rsp_closest_slot,
   output logic [DistW-1:0] rsp_closest_distance_cm,
   output logic signed [SpeedW-1:0] rsp_closing_speed_cms,
   output logic rsp_approaching
);

   cfg_type cfg_ff;
   cmd_type cmd;
   sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.alpha <= 9'd77;
         cfg_ff.interval <= 16'd200;
         cfg_ff.appr_on <= 18'sd50;
         cfg_ff.appr_off <= 18'sd10;
         cfg_ff.coll_dist <= 20'd500;
         cfg_ff.alert_dist <= 20'd3000;
         cfg_ff.ttc <= 16'd3000;
      end else if (csr_write) begin
         unique case (csr_index)
            RegAlpha:     cfg_ff.alpha <= csr_data[8:0];
            RegInterval:  cfg_ff.interval <= csr_data[15:0];
            RegApprOn:    cfg_ff.appr_on <= csr_data[17:0];
            RegApprOff:   cfg_ff.appr_off <= csr_data[17:0];
            RegCollDist:  cfg_ff.coll_dist <= csr_data;
            RegAlertDist: cfg_ff.alert_dist <= csr_data;
            RegTtc:       cfg_ff.ttc <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   pcrt_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_busy(rsp_valid && rsp_stall), .sts(sts), .cmd(cmd)
   );

   pcrt_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
      .clock(clock), .reset(reset), .cfg(cfg_ff), .cmd(cmd), .sts(sts),
      .req_gps_valid(req_gps_valid), .req_present(req_present),
      .req_slot(req_slot), .req_sender_id(req_sender_id),
      .req_raw_distance_cm(req_raw_distance_cm), .req_now_ms(req_now_ms),
      .req_last_in_scan(req_last_in_scan),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_risk_level(rsp_risk_level), .rsp_closest_found(rsp_closest_found),
      .rsp_closest_slot(rsp_closest_slot),
      .rsp_closest_distance_cm(rsp_closest_distance_cm),
      .rsp_closing_speed_cms(rsp_closing_speed_cms),
      .rsp_approaching(rsp_approaching)
   );

endmodule

// ----- src/pcrt_ctrl.sv -----
module pcrt_ctrl
   import pcrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    rsp_busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_LOAD, S_EMA, S_DIV, S_COMMIT, S_EVAL, S_EMIT
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_EMA;
         end
         S_EMA: begin
            priority if (!sts.track) begin
               state_in = sts.last ? S_EVAL : S_IDLE;
            end else if (sts.seed || sts.skip) begin
               state_in = S_COMMIT;
            end else begin
               cmd.ema = 1'b1;
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in = sts.last ? S_EVAL : S_IDLE;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- src/pcrt_dp.sv -----
module pcrt_dp
   import pcrt_pkg::*;
#(
   parameter int unsigned MAX_SLOTS = 8
)
(
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  cmd_type cmd,
   output sts_type sts,
   input  logic req_gps_valid,
   input  logic req_present,
   input  logic [2:0] req_slot,
   input  logic [IdW-1:0] req_sender_id,
   input  logic [DistW-1:0] req_raw_distance_cm,
   input  logic [TimeW-1:0] req_now_ms,
   input  logic req_last_in_scan,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_risk_level,
   output logic rsp_closest_found,
   output logic [2:0] rsp_closest_slot,
   output logic [DistW-1:0] rsp_closest_distance_cm,
   output logic signed [SpeedW-1:0] rsp_closing_speed_cms,
   output logic rsp_approaching
);

   localparam int unsigned NS = MAX_SLOTS;

   // Per-slot state; small, each array read only at the current slot or the best slot.
   logic [NS-1:0] known_ff, hist_ff, appr_ff;
   logic [IdW-1:0] ident_ff [NS];
   logic [DistW-1:0] smooth_ff [NS];
   logic [TimeW-1:0] upd_ff [NS];
   logic signed [SpeedW-1:0] speed_ff [NS];

   logic gps_ff, pres_ff, last_ff;
   logic [2:0] slot_ff;
   logic [IdW-1:0] id_ff;
   logic [DistW-1:0] raw_ff;
   logic [TimeW-1:0] now_ff;

   logic new_ff, appr_cur_ff;
   logic [DistW-1:0] prev_ff, cur_ff;
   logic [TimeW-1:0] dt_ff;
   logic signed [SpeedW-1:0] sp_res_ff;

   logic [DistW-1:0] best_dist_ff;
   logic [2:0] best_slot_ff;
   logic found_ff, bad_ff;

   // Divider state.
   logic [QuotW-1:0] dvd_ff;
   logic [TimeW:0]   rem_ff;
   logic [5:0]       cnt_ff;
   logic             neg_ff;

   logic [DistW+9:0] dprod_ff;
   logic [DistW+16:0] tprod_ff;
   logic [1:0] risk_ff;

   logic in_range;
   logic track_w;
   logic [2:0] s;
   assign s = slot_ff;
   assign in_range = ({29'd0, slot_ff} < 32'(NS));
   assign track_w = gps_ff && pres_ff && in_range;

   logic hist_eff;
   assign hist_eff = hist_ff[s] && !new_ff;

   logic is_new;
   assign is_new = !known_ff[s] || ident_ff[s] != id_ff;

   assign sts.track    = track_w;
   assign sts.seed     = !hist_eff;
   assign sts.skip     = dt_ff < {16'd0, cfg.interval};
   assign sts.last     = last_ff;
   assign sts.div_done = (cnt_ff == 6'd1);

   // EMA.
   logic [8:0] a;
   logic [DistW+8:0] acc;
   assign a = (cfg.alpha > 9'd256) ? 9'd256 : cfg.alpha;
   assign acc = (DistW+9)'(a) * (DistW+9)'(raw_ff)
              + (DistW+9)'(9'd256 - a) * (DistW+9)'(prev_ff) + (DistW+9)'(128);

   // Restoring division step.
   logic [TimeW:0] rem_sh, rem_sub;
   logic [TimeW-1:0] divisor;
   assign divisor = (dt_ff == '0) ? 32'd1 : dt_ff;
   assign rem_sh  = {rem_ff[TimeW-1:0], dvd_ff[QuotW-1]};
   assign rem_sub = rem_sh - {1'b0, divisor};

   logic [DistW:0] diff_abs;
   logic [DistW:0] prev_e, cur_e;
   assign prev_e = {1'b0, prev_ff};
   assign cur_e  = {1'b0, acc[DistW+7:8]};
   assign diff_abs = (prev_e >= cur_e) ? prev_e - cur_e : cur_e - prev_e;

   logic signed [SpeedW-1:0] sp_sat;
   always_comb begin
      if (!neg_ff) begin
         sp_sat = (dvd_ff > QuotW'(131071)) ? SpeedMax : SpeedW'(dvd_ff);
      end else begin
         sp_sat = (dvd_ff > QuotW'(131072)) ? SpeedMin : -SpeedW'(dvd_ff);
      end
   end

   logic appr_next;
   always_comb begin
      appr_next = appr_cur_ff;
      if (!appr_cur_ff && sp_sat >= cfg.appr_on) appr_next = 1'b1;
      else if (appr_cur_ff && sp_sat <= cfg.appr_off) appr_next = 1'b0;
   end

   logic [DistW-1:0] d_new;
   assign d_new = !hist_eff ? raw_ff : (sts.skip ? prev_ff : cur_ff);

   // Evaluation of the best slot.
   logic [2:0] b;
   logic [DistW-1:0] bd;
   logic signed [SpeedW-1:0] bsp;
   logic bap, ok;
   assign b   = best_slot_ff;
   assign bd  = smooth_ff[b];
   assign bsp = speed_ff[b];
   assign bap = appr_ff[b];
   assign ok  = !bad_ff && found_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gps_ff <= req_gps_valid;
         pres_ff <= req_present;
         slot_ff <= req_slot;
         id_ff <= req_sender_id;
         raw_ff <= req_raw_distance_cm;
         now_ff <= req_now_ms;
         last_ff <= req_last_in_scan;
      end
      if (cmd.load) begin
         new_ff <= is_new;
         prev_ff <= is_new ? '0 : smooth_ff[s];
         appr_cur_ff <= is_new ? 1'b0 : appr_ff[s];
         dt_ff <= now_ff - upd_ff[s];
      end
      if (cmd.ema) begin
         cur_ff <= acc[DistW+7:8];
         neg_ff <= cur_e > prev_e;
         dvd_ff <= QuotW'(diff_abs) * QuotW'(1000);
         rem_ff <= '0;
         cnt_ff <= 6'(QuotW);
      end
      if (cmd.div_step) begin
         if (!rem_sub[TimeW]) begin
            rem_ff <= rem_sub;
            dvd_ff <= {dvd_ff[QuotW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dvd_ff <= {dvd_ff[QuotW-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 6'd1;
      end
      if (cmd.commit) begin
         ident_ff[s] <= id_ff;
         smooth_ff[s] <= d_new;
         if (!hist_eff) begin
            upd_ff[s] <= now_ff;
            speed_ff[s] <= '0;
         end else if (!sts.skip) begin
            upd_ff[s] <= now_ff;
            speed_ff[s] <= sp_sat;
         end
         if (!found_ff || d_new < best_dist_ff) begin
            best_dist_ff <= d_new;
            best_slot_ff <= s;
         end
      end
      if (cmd.eval) begin
         dprod_ff <= (DistW+10)'(bd) * (DistW+10)'(1000);
         tprod_ff <= (DistW+17)'(cfg.ttc) * (DistW+17)'($unsigned(bsp));
         if (!ok) risk_ff <= RiskSafe;
         else if (bd <= cfg.coll_dist) risk_ff <= RiskDanger;
         else if (bd <= cfg.alert_dist) risk_ff <= bap ? RiskWarning : RiskAlert;
         else risk_ff <= RiskSafe;
      end
      if (cmd.emit) begin
         rsp_closest_found <= ok;
         rsp_closest_slot <= ok ? b : 3'd0;
         rsp_closest_distance_cm <= ok ? best_dist_ff : '0;
         rsp_closing_speed_cms <= ok ? bsp : '0;
         rsp_approaching <= ok && bap;
         if (ok && risk_ff != RiskDanger && bap && bsp > 0
             && (DistW+17)'(dprod_ff) <= tprod_ff)
            rsp_risk_level <= RiskDanger;
         else
            rsp_risk_level <= risk_ff;
      end
      if (reset) begin
         known_ff <= '0;
         hist_ff <= '0;
         appr_ff <= '0;
         found_ff <= 1'b0;
         bad_ff <= 1'b0;
         best_dist_ff <= '0;
         best_slot_ff <= '0;
         rsp_valid <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (cmd.capture && !req_gps_valid) bad_ff <= 1'b1;
         if (cmd.commit) begin
            known_ff[s] <= 1'b1;
            hist_ff[s] <= 1'b1;
            if (new_ff) appr_ff[s] <= 1'b0;
            if (hist_eff && !sts.skip) appr_ff[s] <= appr_next;
            found_ff <= 1'b1;
         end
         if (cmd.emit) begin
            found_ff <= 1'b0;
            bad_ff <= 1'b0;
            best_dist_ff <= '0;
            best_slot_ff <= '0;
            rsp_valid <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid <= 1'b0;
         end
      end
   end

endmodule

// ----- test/tb_top.sv -----
module tb_top;
   import pcrt_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NumSlots = 8;
   localparam int WatchdogLimit = 4000;
   localparam int SettleCycles = 60;

   typedef struct {
      bit        gps;
      bit        present;
      bit [2:0]  slot;
      bit [47:0] id;
      bit [19:0] raw;
      bit [31:0] now;
      bit        last;
   } report_t;

   typedef struct {
      bit [1:0]         risk;
      bit               found;
      bit [2:0]         slot;
      bit [19:0]        dist_cm;
      bit signed [17:0] speed;
      bit               appr;
   } verdict_t;

   typedef struct {
      report_t  rep;
      bit       typed;
      verdict_t want;
   } row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CfgIdxW-1:0] csr_index = '0;
   logic [CfgW-1:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_gps_valid = 1'b0;
   logic req_present = 1'b0;
   logic [2:0] req_slot = '0;
   logic [IdW-1:0] req_sender_id = '0;
   logic [DistW-1:0] req_raw_distance_cm = '0;
   logic [TimeW-1:0] req_now_ms = '0;
   logic req_last_in_scan = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_risk_level;
   logic rsp_closest_found;
   logic [2:0] rsp_closest_slot;
   logic [DistW-1:0] rsp_closest_distance_cm;
   logic signed [SpeedW-1:0] rsp_closing_speed_cms;
   logic rsp_approaching;

   proximity_collision_risk_tracker_core dut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_gps_valid(req_gps_valid), .req_present(req_present), .req_slot(req_slot),
      .req_sender_id(req_sender_id), .req_raw_distance_cm(req_raw_distance_cm),
      .req_now_ms(req_now_ms), .req_last_in_scan(req_last_in_scan),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_risk_level(rsp_risk_level), .rsp_closest_found(rsp_closest_found),
      .rsp_closest_slot(rsp_closest_slot),
      .rsp_closest_distance_cm(rsp_closest_distance_cm),
      .rsp_closing_speed_cms(rsp_closing_speed_cms), .rsp_approaching(rsp_approaching)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Register copies used by the tracker model.
   bit [8:0]         alpha_q8 = 9'd77;
   bit [15:0]        min_interval = 16'd200;
   bit signed [17:0] appr_on = 18'sd50;
   bit signed [17:0] appr_off = 18'sd10;
   bit [19:0]        coll_cm = 20'd500;
   bit [19:0]        alert_cm = 20'd3000;
   bit [15:0]        ttc_ms = 16'd3000;

   // Per-slot tracking state and the scan in progress.
   bit               trk_known [NumSlots];
   bit [47:0]        trk_id    [NumSlots];
   bit               trk_hist  [NumSlots];
   bit [19:0]        trk_dist  [NumSlots];
   bit [31:0]        trk_stamp [NumSlots];
   bit signed [17:0] trk_speed [NumSlots];
   bit               trk_appr  [NumSlots];
   bit [19:0]        best_dist;
   bit [2:0]         best_slot;
   bit               best_found;
   bit               fix_bad;

   verdict_t scan_results_q[$];
   row_t     typed_q[$];
   int n_reports, n_results, n_errors, n_settings;

   function automatic void update_slot(int s, bit [47:0] id, bit [19:0] raw, bit [31:0] now);
      bit [31:0] dt;
      bit [19:0] prev, cur;
      longint unsigned acc, a;
      longint sp, dv;
      if (!trk_known[s] || trk_id[s] != id) begin
         trk_known[s] = 1; trk_id[s] = id; trk_hist[s] = 0; trk_dist[s] = 0;
         trk_stamp[s] = 0; trk_speed[s] = 0; trk_appr[s] = 0;
      end
      if (!trk_hist[s]) begin
         trk_dist[s] = raw; trk_stamp[s] = now; trk_hist[s] = 1;
         return;
      end
      dt = now - trk_stamp[s];
      if (dt < min_interval) return;
      a = (alpha_q8 > 256) ? 256 : alpha_q8;
      prev = trk_dist[s];
      acc = a * raw + (256 - a) * prev + 128;
      cur = acc[27:8];
      trk_dist[s] = cur;
      dv = (dt == 0) ? 1 : longint'(dt);
      sp = (longint'(prev) - longint'(cur)) * 1000 / dv;
      if (sp > 131071) sp = 131071;
      if (sp < -131072) sp = -131072;
      trk_speed[s] = sp[17:0];
      if (!trk_appr[s] && sp >= longint'(appr_on)) trk_appr[s] = 1;
      else if (trk_appr[s] && sp <= longint'(appr_off)) trk_appr[s] = 0;
      trk_stamp[s] = now;
   endfunction

   function automatic bit predict_scan(report_t r, output verdict_t v);
      bit [19:0] d;
      longint sp;
      v = '{default: 0};
      if (!r.gps) fix_bad = 1;
      else if (r.present && r.slot < NumSlots) begin
         update_slot(r.slot, r.id, r.raw, r.now);
         d = trk_dist[r.slot];
         if (!best_found || d < best_dist) begin
            best_found = 1; best_dist = d; best_slot = r.slot;
         end
      end
      if (!r.last) return 0;
      if (!fix_bad && best_found) begin
         d = trk_dist[best_slot];
         sp = trk_speed[best_slot];
         v.risk = RiskSafe;
         if (d <= coll_cm) v.risk = RiskDanger;
         else if (trk_appr[best_slot] && sp > 0 &&
                  longint'(d) * 1000 <= longint'(ttc_ms) * sp) v.risk = RiskDanger;
         else if (d <= alert_cm) v.risk = trk_appr[best_slot] ? RiskWarning : RiskAlert;
         v.found = 1; v.slot = best_slot; v.dist_cm = best_dist;
         v.speed = trk_speed[best_slot]; v.appr = trk_appr[best_slot];
      end
      best_dist = 0; best_slot = 0; best_found = 0; fix_bad = 0;
      return 1;
   endfunction

   function automatic void check_field(string name, longint want, longint got, bit known);
      if (!known || want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin
      verdict_t v, w;
      row_t t;
      if (!reset) begin
         if (csr_write) begin
            case (csr_index)
               RegAlpha:     alpha_q8 = csr_data[8:0];
               RegInterval:  min_interval = csr_data[15:0];
               RegApprOn:    appr_on = csr_data[17:0];
               RegApprOff:   appr_off = csr_data[17:0];
               RegCollDist:  coll_cm = csr_data;
               RegAlertDist: alert_cm = csr_data;
               RegTtc:       ttc_ms = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            report_t r;
            r = '{req_gps_valid, req_present, req_slot, req_sender_id,
                  req_raw_distance_cm, req_now_ms, req_last_in_scan};
            t = typed_q.pop_front();
            n_reports++;
            if (predict_scan(r, v)) scan_results_q.push_back(t.typed ? t.want : v);
         end
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (scan_results_q.size() == 0) begin
               $error("scan result arrived with none outstanding");
               n_errors++;
            end else begin
               w = scan_results_q.pop_front();
               check_field("risk_level", w.risk, rsp_risk_level, !$isunknown(rsp_risk_level));
               check_field("closest_found", w.found, rsp_closest_found,
                           !$isunknown(rsp_closest_found));
               check_field("closest_slot", w.slot, rsp_closest_slot,
                           !$isunknown(rsp_closest_slot));
               check_field("closest_distance_cm", w.dist_cm, rsp_closest_distance_cm,
                           !$isunknown(rsp_closest_distance_cm));
               check_field("closing_speed_cms", w.speed, rsp_closing_speed_cms,
                           !$isunknown(rsp_closing_speed_cms));
               check_field("approaching", w.appr, rsp_approaching,
                           !$isunknown(rsp_approaching));
            end
         end
      end
   end

   // Result side back-pressure: free-running, bursty, or mostly stalled.
   int stall_mode = 0, stall_left = 0;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 2);
         stall_left <= $urandom_range(20, 200);
      end else stall_left <= stall_left - 1;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= $urandom_range(0, 1);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
   end

   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("Timeout: no item moved for %0d cycles", WatchdogLimit);
         $display("Simulation FAILED");
         $finish;
      end
   end

   int burst_left = 0;

   task automatic send_report(report_t r, bit typed, verdict_t want);
      int gap;
      row_t t;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      t.rep = r; t.typed = typed; t.want = want;
      typed_q.push_back(t);
      req_gps_valid <= r.gps;
      req_present <= r.present;
      req_slot <= r.slot;
      req_sender_id <= r.id;
      req_raw_distance_cm <= r.raw;
      req_now_ms <= r.now;
      req_last_in_scan <= r.last;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // Registers change only once the block has drained, including any
   // report still being worked on that produces no scan result.
   task automatic program_regs(bit [19:0] vals[7]);
      req_valid <= 1'b0;
      while (scan_results_q.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      for (int i = 0; i < 7; i++) begin
         csr_write <= 1'b1;
         csr_index <= i[CfgIdxW-1:0];
         csr_data <= vals[i];
         @(posedge clock);
      end
      csr_write <= 1'b0;
      n_settings++;
   endtask

   row_t plan[$];

   function automatic void add_row(bit g, bit p, bit [2:0] s, bit [47:0] id, bit [19:0] raw,
                                   bit [31:0] now, bit last, bit typed = 0,
                                   verdict_t want = '{default: 0});
      row_t t;
      t.rep = '{g, p, s, id, raw, now, last};
      t.typed = typed;
      t.want = want;
      plan.push_back(t);
   endfunction

   initial begin
      bit [19:0] regs[7];
      bit [47:0] id_pool[NumSlots][2];
      int walk[NumSlots];
      bit [31:0] ms;
      report_t r;
      verdict_t none;
      int tracked, n_scan;

      none = '{default: 0};
      for (int i = 0; i < NumSlots; i++) begin
         trk_known[i] = 0; trk_hist[i] = 0; trk_appr[i] = 0;
      end

      // Invalid fix and an empty scan both report safe with nothing found.
      add_row(0, 1, 3'd1, 48'h1, 20'd100, 32'd0, 1, 1, none);
      add_row(1, 0, 3'd3, 48'h2, 20'd100, 32'd0, 1, 1, none);
      // A first report only seeds the distance: zero is danger, the maximum is safe.
      add_row(1, 1, 3'd0, 48'h0, 20'd0, 32'd0, 1, 1, '{RiskDanger, 1, 3'd0, 20'd0, 0, 0});
      add_row(1, 1, 3'd7, '1, 20'hFFFFF, 32'd100, 1, 1,
              '{RiskSafe, 1, 3'd7, 20'hFFFFF, 0, 0});
      // Seed, update, a report inside the interval, then a new identity.
      add_row(1, 1, 3'd5, 48'h123, 20'd2000, 32'd1000, 0);
      add_row(1, 1, 3'd5, 48'h123, 20'd1000, 32'd2000, 1);
      add_row(1, 1, 3'd5, 48'h123, 20'd900, 32'd2050, 1);
      add_row(1, 1, 3'd5, 48'h456, 20'd4000, 32'd3000, 1);
      // Equal distances: the slot seen first keeps the lead.
      add_row(1, 1, 3'd2, 48'hA, 20'd2500, 32'd5000, 0);
      add_row(1, 1, 3'd1, 48'hB, 20'd2500, 32'd5000, 1);
      // The same slot twice in one scan.
      add_row(1, 1, 3'd4, 48'hC, 20'd1000, 32'd6000, 0);
      add_row(1, 1, 3'd4, 48'hC, 20'd800, 32'd6300, 1);
      // A bad fix late in a scan overrides what was found.
      add_row(1, 1, 3'd0, 48'h0, 20'd50, 32'd6500, 0);
      add_row(0, 1, 3'd0, 48'h0, 20'd50, 32'd6500, 1, 1, none);
      // Far to near in one step saturates the closing speed.
      add_row(1, 1, 3'd6, 48'hD, 20'hFFFFF, 32'd7000, 1);
      add_row(1, 1, 3'd6, 48'hD, 20'd0, 32'd7200, 1);
      // Timestamp wrapping between two reports.
      add_row(1, 1, 3'd3, 48'hE, 20'd3000, 32'hFFFF_FF00, 1);
      add_row(1, 1, 3'd3, 48'hE, 20'd2000, 32'h0000_0100, 1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) send_report(plan[i].rep, plan[i].typed, plan[i].want);

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: regs = '{20'd256, 20'd0, 20'h1FFFF, 20'h20000, 20'd0, 20'hFFFFF, 20'hFFFF};
            1: regs = '{20'd511, 20'hFFFF, 20'h20000, 20'h1FFFF, 20'hFFFFF, 20'd0, 20'd0};
            2: regs = '{20'd0, 20'd0, 20'd0, 20'd0, 20'd500, 20'd3000, 20'd3000};
            default: begin
               regs[0] = $urandom_range(0, 300);
               regs[1] = $urandom_range(0, 400);
               regs[2] = 20'(18'($urandom_range(0, 600) - 200));
               regs[3] = 20'(18'($urandom_range(0, 400) - 300));
               regs[4] = $urandom_range(0, 2000);
               regs[5] = $urandom_range(1000, 8000);
               regs[6] = $urandom_range(0, 10000);
            end
         endcase
         program_regs(regs);

         ms = $urandom;
         for (int i = 0; i < NumSlots; i++) begin
            id_pool[i][0] = {$urandom, $urandom};
            id_pool[i][1] = {$urandom, $urandom};
            walk[i] = $urandom_range(0, 6000);
         end
         tracked = 0;
         while (tracked < 240) begin
            n_scan = $urandom_range(1, 8);
            ms += (min_interval > 1000) ? $urandom_range(0, 70000) : $urandom_range(0, 400);
            for (int k = 0; k < n_scan; k++) begin
               r.gps = ($urandom_range(0, 39) != 0);
               r.present = ($urandom_range(0, 11) != 0);
               r.slot = $urandom_range(0, 7);
               r.id = ($urandom_range(0, 19) == 0) ? {$urandom, $urandom}
                      : id_pool[r.slot][$urandom_range(0, 5) == 0];
               walk[r.slot] += $urandom_range(0, 500) - 300;
               if (walk[r.slot] < 0) walk[r.slot] = 0;
               r.raw = ($urandom_range(0, 24) == 0) ? 20'($urandom) : 20'(walk[r.slot]);
               r.now = ($urandom_range(0, 49) == 0) ? $urandom : ms + $urandom_range(0, 3);
               r.last = (k == n_scan - 1) || ($urandom_range(0, 19) == 0);
               tracked++;
               send_report(r, 0, none);
            end
         end
      end

      req_valid <= 1'b0;
      while (scan_results_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Covered %0d distance reports and %0d scan results under %0d register settings.",
               n_reports, n_results, n_settings);
      if (n_errors == 0 && scan_results_q.size() == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
src/pcrt_pkg.sv
src/pcrt_ctrl.sv
src/pcrt_dp.sv
src/proximity_collision_risk_tracker_core.sv
test/tb_top.sv
